FILE: rtl/lets_pkg.sv
// lets_pkg: shared types and constants of the logic edge timestamper
// no dependencies; used by lets_cell and logic_edge_timestamper_top

package lets_pkg;

    // field widths
    localparam int SAMPLE_W = 8;
    localparam int CHAN_W   = 3;
    localparam int TIME_W   = 64;
    localparam int NS_W     = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;

    // input beat kinds carried in s_tuser
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALLING  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NS       = 3'd4;

    // reset values of the configuration registers
    localparam logic [CHAN_W-1:0] RECEIVER_RESET = 3'd1;
    localparam logic [NS_W-1:0]   NS_RESET       = 30'd125;

    // one pending edge event held in a cell
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic              stop;
    } slot_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic capture;   // take the masked sample as the new previous level
        logic load;      // load the edge event of this sample into the slot
        logic shift;     // move slots one place towards the head
    } cell_ctrl_t;

endpackage

FILE: rtl/lets_cell.sv
// lets_cell: one channel of the edge detection row
// holds the previous level and one event slot; depends on lets_pkg

module lets_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lets_pkg::cell_ctrl_t      ctrl,
    input  logic                      cur_bit,
    input  logic                      rise_en,
    input  logic                      fall_en,
    input  logic [lets_pkg::CHAN_W-1:0] rx_sel,
    input  lets_pkg::slot_t           slot_in,
    output lets_pkg::slot_t           slot_out
);

    localparam logic [lets_pkg::CHAN_W-1:0] CH = lets_pkg::CHAN_W'(IDX);

    logic            prev_reg;
    logic            prev_next;
    lets_pkg::slot_t slot_reg;
    lets_pkg::slot_t slot_next;
    lets_pkg::slot_t own_event;
    logic            changed;
    logic            is_rx;

    // edge classification of this channel
    always_comb
    begin
        changed = cur_bit ^ prev_reg;
        is_rx   = (rx_sel == CH);
        own_event.channel = CH;
        own_event.level   = cur_bit;
        own_event.stop    = is_rx;
        if (is_rx)
        begin
            own_event.valid = changed & cur_bit;
        end
        else
        begin
            own_event.valid = changed & (cur_bit ? rise_en : fall_en);
        end
    end

    // slot load, shift or hold
    always_comb
    begin
        prev_next = ctrl.capture ? cur_bit : prev_reg;
        if (ctrl.load)
        begin
            slot_next = own_event;
        end
        else if (ctrl.shift)
        begin
            slot_next = slot_in;
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    // previous level and event slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            slot_reg <= slot_next;
        end
    end

    assign slot_out = slot_reg;

endmodule

FILE: rtl/logic_edge_timestamper_top.sv
// logic_edge_timestamper_top: sample sequencer, time stamp multiply and output register
// instantiates a row of lets_cell; depends on lets_pkg
//
// channel  dir  beat contents
// s_*      in   tdata[7:0] sample_bits; tuser op (0 start, 1 sample)
// m_*      out  tdata channel, level, time_ns; tuser trace_stop; tlast last_of_run
// cfg_*    in   register index and write data, one write per cycle, no wait
//
// a start beat or a priming sample is only accepted and leaves the block ready
// any other sample is accepted, then passes the states MUL_LO and MUL_HI of the split
// 64 x 30 multiply and then SUM; ST_SCAN then shifts the events out of the cells, one
// event shift per cycle while m_tready allows, until no cell holds an event; a stalled
// m_tready holds the cell row; reset leaves the block ready at once

module logic_edge_timestamper_top #(
    parameter int CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample_bits
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] channel, [3] level, [67:4] time_ns, zero above
    output logic        m_tuser,   // [0] trace_stop
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [lets_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lets_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LANES = (CHANNELS < lets_pkg::SAMPLE_W) ? CHANNELS : lets_pkg::SAMPLE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;

    // configuration
    logic [lets_pkg::SAMPLE_W-1:0] enable_reg;
    logic [lets_pkg::SAMPLE_W-1:0] rising_reg;
    logic [lets_pkg::SAMPLE_W-1:0] falling_reg;
    logic [lets_pkg::CHAN_W-1:0]   receiver_reg;
    logic [lets_pkg::NS_W-1:0]     ns_reg;

    // sequencer and counter
    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        awaiting_reg;
    logic                        awaiting_next;
    logic [lets_pkg::TIME_W-1:0] counter_reg;
    logic [lets_pkg::TIME_W-1:0] counter_next;

    // time stamp datapath
    logic [lets_pkg::TIME_W-1:0] cnt_lat_reg;
    logic [61:0]                 p_lo_reg;
    logic [31:0]                 p_hi_reg;
    logic [lets_pkg::TIME_W-1:0] stamp_reg;
    logic [31:0]                 p_hi_full;

    // output register
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lets_pkg::CHAN_W-1:0] out_chan_reg;
    logic                        out_level_reg;
    logic                        out_stop_reg;
    logic                        out_last_reg;
    logic [lets_pkg::TIME_W-1:0] out_time_reg;

    logic                        accept;
    logic                        sample_acc;
    logic                        can_move;
    logic                        any_valid;
    logic                        rest_valid;
    logic                        out_load;
    lets_pkg::cell_ctrl_t        ctrl;
    lets_pkg::slot_t             slots [LANES+1];
    logic [lets_pkg::SAMPLE_W-1:0] cur;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign sample_acc = accept && (s_tuser == lets_pkg::OP_SAMPLE);
    assign cur        = s_tdata & enable_reg;
    assign can_move   = !out_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            rising_reg   <= '0;
            falling_reg  <= '0;
            receiver_reg <= lets_pkg::RECEIVER_RESET;
            ns_reg       <= lets_pkg::NS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lets_pkg::REG_ENABLE:   enable_reg   <= cfg_data[lets_pkg::SAMPLE_W-1:0];
                lets_pkg::REG_RISING:   rising_reg   <= cfg_data[lets_pkg::SAMPLE_W-1:0];
                lets_pkg::REG_FALLING:  falling_reg  <= cfg_data[lets_pkg::SAMPLE_W-1:0];
                lets_pkg::REG_RECEIVER: receiver_reg <= cfg_data[lets_pkg::CHAN_W-1:0];
                lets_pkg::REG_NS:       ns_reg       <= cfg_data[lets_pkg::NS_W-1:0];
                default: ;
            endcase
        end
    end

    // cell row status
    always_comb
    begin
        any_valid  = 1'b0;
        rest_valid = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            any_valid = any_valid | slots[k].valid;
            if (k > 0)
            begin
                rest_valid = rest_valid | slots[k].valid;
            end
        end
    end

    // control to the cells
    always_comb
    begin
        ctrl.capture = sample_acc;
        ctrl.load    = sample_acc && !awaiting_reg;
        ctrl.shift   = (state_reg == ST_SCAN) && can_move && any_valid;
    end

    assign out_load = ctrl.shift && slots[0].valid;
    assign slots[LANES] = '0;

    // row of channel cells, slot k fed from slot k+1
    for (genvar k = 0; k < LANES; k++)
    begin : g_cell
        lets_cell #(
            .IDX(k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .cur_bit  (cur[k]),
            .rise_en  (rising_reg[k]),
            .fall_en  (falling_reg[k]),
            .rx_sel   (receiver_reg),
            .slot_in  (slots[k+1]),
            .slot_out (slots[k])
        );
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        awaiting_next = awaiting_reg;
        counter_next  = counter_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_tuser == lets_pkg::OP_START))
                begin
                    counter_next  = '0;
                    awaiting_next = 1'b1;
                end
                else if (sample_acc)
                begin
                    counter_next  = counter_reg + 64'd1;
                    awaiting_next = 1'b0;
                    if (!awaiting_reg)
                    begin
                        state_next = ST_MUL_LO;
                    end
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (!any_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            awaiting_reg <= 1'b1;
            counter_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            awaiting_reg <= awaiting_next;
            counter_reg  <= counter_next;
        end
    end

    // time stamp: low and high halves of the count times ns, then the sum
    assign p_hi_full = cnt_lat_reg[63:32] * {2'b00, ns_reg};

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            cnt_lat_reg <= counter_reg;
        end
        if (state_reg == ST_MUL_LO)
        begin
            p_lo_reg <= {30'd0, cnt_lat_reg[31:0]} * {32'd0, ns_reg};
        end
        if (state_reg == ST_MUL_HI)
        begin
            p_hi_reg <= p_hi_full;
        end
        if (state_reg == ST_SUM)
        begin
            stamp_reg <= {2'b00, p_lo_reg} + {p_hi_reg, 32'd0};
        end
    end

    // output register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_chan_reg  <= slots[0].channel;
            out_level_reg <= slots[0].level;
            out_stop_reg  <= slots[0].stop;
            out_last_reg  <= !rest_valid;
            out_time_reg  <= stamp_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_time_reg, out_level_reg, out_chan_reg};
    assign m_tuser  = out_stop_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // no event may remain in the row while a new beat can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !any_valid)
        else $error("cell row not empty while ready");

    // the last event of a sample leaves the row empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !rest_valid) |=> !any_valid)
        else $error("events left behind the last beat");

    // multiply steps run in fixed order into the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_LO) |=> (state_reg == ST_MUL_HI))
        else $error("multiply sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |=> (state_reg == ST_SCAN))
        else $error("sum not followed by scan");

    // a priming sample gives no event and keeps the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_acc && awaiting_reg) |=> ((state_reg == ST_IDLE) && !any_valid))
        else $error("priming sample produced work");
`endif

endmodule
